// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions in the field editor RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the usual clk_i and rst_ni of the enclosing module.
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_RST(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hw/rtl/cte_pkg.sv =====
// ---------------------------------------------------------------------------
// cte_pkg
// Types, codes and limits shared by the clock and date field editor.
// ---------------------------------------------------------------------------
package cte_pkg;

  typedef enum logic [2:0] {
    STEP_IDLE    = 3'd0,
    STEP_YEAR    = 3'd1,
    STEP_MONTH   = 3'd2,
    STEP_DATE    = 3'd3,
    STEP_HOURS   = 3'd4,
    STEP_MINUTES = 3'd5,
    STEP_SECONDS = 3'd6
  } step_e;

  typedef enum logic [2:0] {
    EV_LOAD = 3'd0,
    EV_NEXT = 3'd1,
    EV_PREV = 3'd2,
    EV_INC  = 3'd3,
    EV_DEC  = 3'd4
  } event_e;

  localparam logic [6:0] YEAR_MAX    = 7'd99;
  localparam logic [6:0] MONTH_MAX   = 7'd12;
  localparam logic [6:0] HOURS_MAX   = 7'd23;
  localparam logic [6:0] MINSEC_MAX  = 7'd59;
  localparam logic [6:0] ZERO_MIN    = 7'd0;
  localparam logic [6:0] ONE_MIN     = 7'd1;
  localparam logic [4:0] DAYS_SHORT  = 5'd28;
  localparam logic [4:0] DAYS_MEDIUM = 5'd30;
  localparam logic [4:0] DAYS_LONG   = 5'd31;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] load_year;
    logic [3:0] load_month;
    logic [4:0] load_date;
    logic [4:0] load_hours;
    logic [5:0] load_minutes;
    logic [5:0] load_seconds;
  } cte_event_t;

  typedef struct packed {
    logic [2:0] selected_field;
    logic [6:0] year_out;
    logic [3:0] month_out;
    logic [4:0] date_out;
    logic [4:0] hours_out;
    logic [5:0] minutes_out;
    logic [5:0] seconds_out;
    logic       commit;
  } cte_result_t;

  // Flow control between the input register and the result register.
  typedef struct packed {
    logic fire;
    logic advance;
  } cte_flow_t;

  // Number of days in a month, no leap years; invalid months get the long limit.
  function automatic logic [4:0] month_length(input logic [3:0] m);
    logic [4:0] days;
    case (m)
      4'd2:                     days = DAYS_SHORT;
      4'd4, 4'd6, 4'd9, 4'd11:  days = DAYS_MEDIUM;
      default:                  days = DAYS_LONG;
    endcase
    return days;
  endfunction

  // Step a value up or down by one, wrapping between lo and hi.
  function automatic logic [6:0] bump(input logic [6:0] v, input logic [6:0] lo,
                                      input logic [6:0] hi, input logic up);
    logic [6:0] r;
    if (up) begin
      r = (v < hi) ? v + 7'd1 : lo;
    end else begin
      r = (v > lo) ? v - 7'd1 : hi;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/cte_if.sv =====
// ---------------------------------------------------------------------------
// Field editor channels
// Valid/ready channels for button events and edited time results.
// ---------------------------------------------------------------------------
interface cte_event_if;
  logic                valid;
  logic                ready;
  cte_pkg::cte_event_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cte_result_if;
  logic                 valid;
  logic                 ready;
  cte_pkg::cte_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cte_in_stage.sv =====
// ---------------------------------------------------------------------------
// cte_in_stage
// Input register that holds one event until the edit logic consumes it.
// ---------------------------------------------------------------------------
module cte_in_stage import cte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  cte_event_if.sink         evt_i,
  input  logic              advance_i,
  output logic              valid_o,
  output cte_event_t        data_o
);

  logic       valid_q, valid_d;
  cte_event_t data_q;
  logic       take;

  assign evt_i.ready = !valid_q || advance_i;
  assign take        = evt_i.valid && evt_i.ready;
  assign valid_d     = take || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= evt_i.data;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/cte_edit_core.sv =====
// ---------------------------------------------------------------------------
// cte_edit_core
// Edit state and the update of selection and time fields.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cte_edit_core import cte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  cte_event_t  evt_i,
  output cte_result_t res_o
);

  step_e      step_q, step_d;
  logic [6:0] year_q, year_d;
  logic [3:0] month_q, month_d;
  logic [4:0] date_q, date_d;
  logic [4:0] hours_q, hours_d;
  logic [5:0] minutes_q, minutes_d;
  logic [5:0] seconds_q, seconds_d;
  logic       commit;
  logic       up;
  logic [6:0] date_max;

  assign up       = (event_e'(evt_i.mode) == EV_INC);
  assign date_max = 7'(month_length(month_q));

  always_comb begin
    step_d    = step_q;
    year_d    = year_q;
    month_d   = month_q;
    date_d    = date_q;
    hours_d   = hours_q;
    minutes_d = minutes_q;
    seconds_d = seconds_q;
    commit    = 1'b0;
    unique case (event_e'(evt_i.mode)) inside
      EV_LOAD: begin
        step_d    = STEP_YEAR;
        year_d    = evt_i.load_year;
        month_d   = evt_i.load_month;
        date_d    = evt_i.load_date;
        hours_d   = evt_i.load_hours;
        minutes_d = evt_i.load_minutes;
        seconds_d = evt_i.load_seconds;
      end
      EV_NEXT: begin
        if (step_q == STEP_SECONDS) begin
          step_d = STEP_IDLE;
          commit = 1'b1;
        end else if (step_q != STEP_IDLE) begin
          step_d = step_e'(step_q + 3'd1);
        end
      end
      EV_PREV: begin
        // Year is the first field, so previous stays there.
        if (step_q > STEP_YEAR) begin
          step_d = step_e'(step_q - 3'd1);
        end
      end
      EV_INC, EV_DEC: begin
        unique case (step_q)
          STEP_IDLE:    ;
          STEP_YEAR:    year_d = bump(year_q, ZERO_MIN, YEAR_MAX, up);
          STEP_MONTH:   month_d = 4'(bump(7'(month_q), ONE_MIN, MONTH_MAX, up));
          STEP_DATE:    date_d = 5'(bump(7'(date_q), ONE_MIN, date_max, up));
          STEP_HOURS:   hours_d = 5'(bump(7'(hours_q), ZERO_MIN, HOURS_MAX, up));
          STEP_MINUTES: minutes_d = 6'(bump(7'(minutes_q), ZERO_MIN, MINSEC_MAX, up));
          default:      seconds_d = 6'(bump(7'(seconds_q), ZERO_MIN, MINSEC_MAX, up));
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= STEP_IDLE;
      year_q    <= '0;
      month_q   <= '0;
      date_q    <= '0;
      hours_q   <= '0;
      minutes_q <= '0;
      seconds_q <= '0;
    end else if (fire_i) begin
      step_q    <= step_d;
      year_q    <= year_d;
      month_q   <= month_d;
      date_q    <= date_d;
      hours_q   <= hours_d;
      minutes_q <= minutes_d;
      seconds_q <= seconds_d;
    end
  end

  assign res_o.selected_field = step_d;
  assign res_o.year_out       = year_d;
  assign res_o.month_out      = month_d;
  assign res_o.date_out       = date_d;
  assign res_o.hours_out      = hours_d;
  assign res_o.minutes_out    = minutes_d;
  assign res_o.seconds_out    = seconds_d;
  assign res_o.commit         = commit;

  `ASSERT_DEF(a_commit_goes_idle, fire_i && commit |=> step_q == STEP_IDLE,
              "commit did not return the editor to idle")
  `ASSERT_DEF(a_commit_from_seconds, commit |-> step_q == STEP_SECONDS,
              "commit raised outside the seconds field")
  `ASSERT_DEF(a_load_selects_year,
              fire_i && event_e'(evt_i.mode) == EV_LOAD |=> step_q == STEP_YEAR,
              "load did not select the year field")

endmodule

// ===== hw/rtl/cte_out_stage.sv =====
// ---------------------------------------------------------------------------
// cte_out_stage
// Result register that holds an edited time until the receiver takes it.
// ---------------------------------------------------------------------------
module cte_out_stage import cte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  cte_result_t data_i,
  output logic        advance_o,
  cte_result_if.source res_o
);

  logic        valid_q, valid_d;
  cte_result_t data_q;

  assign advance_o = !valid_q || res_o.ready;
  assign valid_d   = load_i || (valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign res_o.valid = valid_q;
  assign res_o.data  = data_q;

endmodule

// ===== hw/rtl/clock_time_field_editor.sv =====
// ---------------------------------------------------------------------------
// clock_time_field_editor
// Button driven editor for the year, month, date, hours, minutes and seconds.
// ---------------------------------------------------------------------------
// Usage:
// Events arrive on evt_i (valid/ready); each transfer carries one button
// event and, for a load, the present time. Every event gives exactly one
// transfer on res_o with the selected field, all six edited values and a
// commit flag that is set when next on the seconds field writes the time.
// An event passes the input register and the edit logic, then waits in
// the result register, which raises res_o.valid. One event is taken every
// cycle while res_o.ready is high; the single update of the edit state per
// cycle sets that rate.
// Reset clears both registers' valid flags, selects no field and zeroes
// all six values. When the receiver holds res_o.ready low, the result
// stays put, the event behind it waits in the input register, and
// evt_i.ready drops once both are full.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module clock_time_field_editor import cte_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  cte_event_if.sink     evt_i,
  cte_result_if.source  res_o
);

  logic        s1_valid;
  cte_event_t  s1_data;
  cte_result_t edit_res;
  cte_flow_t   flow;

  cte_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .evt_i     (evt_i),
    .advance_i (flow.advance),
    .valid_o   (s1_valid),
    .data_o    (s1_data)
  );

  assign flow.fire = s1_valid && flow.advance;

  cte_edit_core u_edit_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (flow.fire),
    .evt_i  (s1_data),
    .res_o  (edit_res)
  );

  cte_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (flow.fire),
    .data_i    (edit_res),
    .advance_o (flow.advance),
    .res_o     (res_o)
  );

  `ASSERT_DEF(a_fire_fills_result, flow.fire |=> res_o.valid,
              "an edited event did not reach the result register")

endmodule
